// File: rtl/core/ssde_pkg.sv
// ----------------------------------------------------------------------------
// ssde_pkg
// Shared types, constants and saturating arithmetic for the sparse squared
// distance engine.
// ----------------------------------------------------------------------------
package ssde_pkg;

   localparam int IDX_BITS      = 12;
   localparam int DATA_BITS     = 32;
   localparam int ACC_BITS      = 64;
   localparam int CNT_BITS      = 32;
   localparam int EPOCH_BITS    = 8;
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = 3;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_CAND  = 1'b1;

   typedef logic signed [ACC_BITS-1:0] acc_type;

   localparam acc_type ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam acc_type ACC_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      acc_type value;
      logic    ovf;
   } sat_type;

   // One entry after the multiply stage.
   typedef struct packed {
      logic    valid;
      logic    op;
      logic    last;
      logic    start;
      logic    in_range;
      acc_type sq;
      acc_type dp;
   } prod_type;

   typedef struct packed {
      acc_type               distance;
      logic [CNT_BITS-1:0]   candidate_number;
      logic                  overflow;
   } rsp_type;

   function automatic sat_type add_sat(input acc_type a, input acc_type b);
      logic [ACC_BITS:0] s;
      sat_type           r;
      s       = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
      r.ovf   = s[ACC_BITS] ^ s[ACC_BITS-1];
      r.value = r.ovf ? (s[ACC_BITS] ? ACC_MIN : ACC_MAX) : acc_type'(s[ACC_BITS-1:0]);
      return r;
   endfunction

   function automatic sat_type sub_sat(input acc_type a, input acc_type b);
      logic [ACC_BITS:0] s;
      sat_type           r;
      s       = {a[ACC_BITS-1], a} - {b[ACC_BITS-1], b};
      r.ovf   = s[ACC_BITS] ^ s[ACC_BITS-1];
      r.value = r.ovf ? (s[ACC_BITS] ? ACC_MIN : ACC_MAX) : acc_type'(s[ACC_BITS-1:0]);
      return r;
   endfunction

endpackage

// File: rtl/core/ssde_ram.sv
// ----------------------------------------------------------------------------
// ssde_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ssde_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ssde_front.sv
// ----------------------------------------------------------------------------
// ssde_front
// Input side: query scatter into the store, candidate gather, store clearing
// and the two multipliers.
// ----------------------------------------------------------------------------
module ssde_front #(
   parameter int FEATURE_COUNT = 4096,
   parameter int VALUE_BITS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [ssde_pkg::IDX_BITS-1:0] req_feature_index,
   input  logic [ssde_pkg::DATA_BITS-1:0] req_value,
   input  logic                          req_last,
   input  logic                          credit_full,
   output ssde_pkg::prod_type            prod
);

   localparam int ADDR_W = $clog2(FEATURE_COUNT);
   localparam int IW     = ((ADDR_W > ssde_pkg::IDX_BITS) ? ADDR_W : ssde_pkg::IDX_BITS) + 1;
   localparam int RAM_W  = VALUE_BITS + ssde_pkg::EPOCH_BITS;

   logic                              loading_ff, loading_in;
   logic [ssde_pkg::EPOCH_BITS-1:0]   epoch_ff, epoch_in, epoch_next;
   logic                              clearing_ff, clearing_in;
   logic [ADDR_W-1:0]                 clear_addr_ff, clear_addr_in;

   logic                              accept, start, wrap_hit, in_range;
   logic [IW-1:0]                     idx_ext;
   logic [ADDR_W-1:0]                 addr;
   logic signed [VALUE_BITS-1:0]      value_s;

   logic                              ram_we;
   logic [ADDR_W-1:0]                 ram_waddr;
   logic [RAM_W-1:0]                  ram_wdata, ram_rdata;

   logic                              s1_valid_ff;
   logic                              s1_op_ff, s1_last_ff, s1_start_ff, s1_in_range_ff;
   logic signed [VALUE_BITS-1:0]      s1_value_ff;
   logic [ssde_pkg::EPOCH_BITS-1:0]   s1_epoch_ff;

   logic                              hit;
   logic signed [VALUE_BITS-1:0]      store_val, mult_b;
   logic signed [2*VALUE_BITS-1:0]    sq_w, dp_w;
   ssde_pkg::prod_type                prod_ff, prod_in;

   assign idx_ext  = IW'(req_feature_index);
   assign in_range = idx_ext < IW'(FEATURE_COUNT);
   assign addr     = idx_ext[ADDR_W-1:0];
   assign value_s  = req_value[VALUE_BITS-1:0];

   assign start    = (req_op == ssde_pkg::OP_QUERY) && !loading_ff;
   // Epoch about to wrap: hold the new query until the store is swept.
   assign wrap_hit = req_valid && start && (epoch_ff == '1);

   assign req_stall  = clearing_ff || credit_full || wrap_hit;
   assign accept     = req_valid && !req_stall;
   assign epoch_next = start ? ssde_pkg::EPOCH_BITS'(epoch_ff + 1'b1) : epoch_ff;

   always_comb begin
      loading_in    = loading_ff;
      epoch_in      = epoch_ff;
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = ADDR_W'(clear_addr_ff + 1'b1);
         if (clear_addr_ff == ADDR_W'(FEATURE_COUNT - 1)) begin
            clearing_in   = 1'b0;
            epoch_in      = '0;
            clear_addr_in = '0;
         end
      end else if (wrap_hit) begin
         clearing_in = 1'b1;
      end else if (accept) begin
         epoch_in   = epoch_next;
         loading_in = (req_op == ssde_pkg::OP_QUERY) && !req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loading_ff    <= 1'b0;
         epoch_ff      <= '0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         loading_ff    <= loading_in;
         epoch_ff      <= epoch_in;
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Sweep writes tag zero and value zero, so epoch zero reads as empty.
   assign ram_we    = clearing_ff ||
                      (accept && (req_op == ssde_pkg::OP_QUERY) && in_range);
   assign ram_waddr = clearing_ff ? clear_addr_ff : addr;
   assign ram_wdata = clearing_ff ? '0 : {epoch_next, value_s};

   ssde_ram #(
      .WIDTH (RAM_W),
      .DEPTH (FEATURE_COUNT)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff       <= req_op;
      s1_last_ff     <= req_last;
      s1_start_ff    <= start;
      s1_in_range_ff <= in_range;
      s1_value_ff    <= value_s;
      s1_epoch_ff    <= epoch_next;
   end

   assign store_val = ram_rdata[VALUE_BITS-1:0];
   assign hit       = (s1_op_ff == ssde_pkg::OP_CAND) && s1_in_range_ff &&
                      (ram_rdata[RAM_W-1 -: ssde_pkg::EPOCH_BITS] == s1_epoch_ff);
   assign mult_b    = hit ? store_val : '0;
   assign sq_w      = s1_value_ff * s1_value_ff;
   assign dp_w      = s1_value_ff * mult_b;

   always_comb begin
      prod_in.valid    = s1_valid_ff;
      prod_in.op       = s1_op_ff;
      prod_in.last     = s1_last_ff;
      prod_in.start    = s1_start_ff;
      prod_in.in_range = s1_in_range_ff;
      prod_in.sq       = ssde_pkg::acc_type'(sq_w);
      prod_in.dp       = ssde_pkg::acc_type'(dp_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else begin
         prod_ff.valid <= prod_in.valid;
      end
      prod_ff.op       <= prod_in.op;
      prod_ff.last     <= prod_in.last;
      prod_ff.start    <= prod_in.start;
      prod_ff.in_range <= prod_in.in_range;
      prod_ff.sq       <= prod_in.sq;
      prod_ff.dp       <= prod_in.dp;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/core/ssde_accum.sv
// ----------------------------------------------------------------------------
// ssde_accum
// Norm and dot-product accumulators, then the final combination
// norm_q + norm_c - 2*dot over two register stages.
// ----------------------------------------------------------------------------
module ssde_accum (
   input  logic                clock,
   input  logic                reset,
   input  ssde_pkg::prod_type  prod,
   output logic                push,
   output ssde_pkg::rsp_type   push_data
);

   ssde_pkg::acc_type                  qn_ff, qn_in, dot_ff, dot_in, cn_ff, cn_in;
   logic                               qsat_ff, qsat_in, sat_ff, sat_in;
   logic [ssde_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;

   ssde_pkg::acc_type                  qn_base;
   ssde_pkg::sat_type                  qadd, dadd, cadd;
   logic                               sat_new;

   logic                               f3_valid_ff, f3_valid_in;
   ssde_pkg::acc_type                  f3_qn_ff, f3_cn_ff, f3_dot_ff;
   logic                               f3_flag_ff, f3_flag_in;
   logic [ssde_pkg::CNT_BITS-1:0]      f3_cnt_ff;

   ssde_pkg::sat_type                  s_sum, d2_sum, dist_diff;
   logic                               s4_valid_ff;
   ssde_pkg::acc_type                  s4_s_ff, s4_d2_ff;
   logic                               s4_flag_ff;
   logic [ssde_pkg::CNT_BITS-1:0]      s4_cnt_ff;

   assign qn_base = prod.start ? '0 : qn_ff;
   assign qadd    = ssde_pkg::add_sat(qn_base, prod.sq);
   assign dadd    = ssde_pkg::add_sat(dot_ff, prod.dp);
   assign cadd    = ssde_pkg::add_sat(cn_ff, prod.sq);
   assign sat_new = sat_ff || dadd.ovf || cadd.ovf;

   always_comb begin
      qn_in       = qn_ff;
      qsat_in     = qsat_ff;
      dot_in      = dot_ff;
      cn_in       = cn_ff;
      sat_in      = sat_ff;
      cnt_in      = cnt_ff;
      f3_valid_in = 1'b0;
      f3_flag_in  = sat_new || qsat_ff;
      if (prod.valid) begin
         if (prod.op == ssde_pkg::OP_QUERY) begin
            // First query entry drops any partial candidate.
            if (prod.start) begin
               qn_in   = '0;
               qsat_in = 1'b0;
               dot_in  = '0;
               cn_in   = '0;
               sat_in  = 1'b0;
               cnt_in  = '0;
            end
            if (prod.in_range) begin
               qn_in   = qadd.value;
               qsat_in = (prod.start ? 1'b0 : qsat_ff) || qadd.ovf;
            end
         end else begin
            dot_in = dadd.value;
            cn_in  = cadd.value;
            sat_in = sat_new;
            if (prod.last) begin
               f3_valid_in = 1'b1;
               dot_in      = '0;
               cn_in       = '0;
               sat_in      = 1'b0;
               cnt_in      = ssde_pkg::CNT_BITS'(cnt_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff       <= '0;
         qsat_ff     <= 1'b0;
         dot_ff      <= '0;
         cn_ff       <= '0;
         sat_ff      <= 1'b0;
         cnt_ff      <= '0;
         f3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         qn_ff       <= qn_in;
         qsat_ff     <= qsat_in;
         dot_ff      <= dot_in;
         cn_ff       <= cn_in;
         sat_ff      <= sat_in;
         cnt_ff      <= cnt_in;
         f3_valid_ff <= f3_valid_in;
         s4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f3_qn_ff   <= qn_ff;
      f3_cn_ff   <= cadd.value;
      f3_dot_ff  <= dadd.value;
      f3_flag_ff <= f3_flag_in;
      f3_cnt_ff  <= cnt_ff;
   end

   assign s_sum  = ssde_pkg::add_sat(f3_qn_ff, f3_cn_ff);
   assign d2_sum = ssde_pkg::add_sat(f3_dot_ff, f3_dot_ff);

   always_ff @(posedge clock) begin
      s4_s_ff    <= s_sum.value;
      s4_d2_ff   <= d2_sum.value;
      s4_flag_ff <= f3_flag_ff || s_sum.ovf || d2_sum.ovf;
      s4_cnt_ff  <= f3_cnt_ff;
   end

   assign dist_diff = ssde_pkg::sub_sat(s4_s_ff, s4_d2_ff);

   always_comb begin
      push                       = s4_valid_ff;
      push_data.distance         = dist_diff.value;
      push_data.candidate_number = s4_cnt_ff;
      push_data.overflow         = s4_flag_ff || dist_diff.ovf;
   end

endmodule

// File: rtl/core/ssde_rsp_fifo.sv
// ----------------------------------------------------------------------------
// ssde_rsp_fifo
// Register FIFO holding finished results until the receiver takes them.
// ----------------------------------------------------------------------------
module ssde_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssde_pkg::rsp_type  push_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ssde_pkg::rsp_type  rsp_data
);

   localparam int PW = ssde_pkg::FIFO_PTR_BITS;

   ssde_pkg::rsp_type entries_ff [ssde_pkg::FIFO_DEPTH];
   logic [PW:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic              pop;

   assign rsp_valid = wr_ptr_ff != rd_ptr_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entries_ff[rd_ptr_ff[PW-1:0]];
   assign wr_ptr_in = push ? (PW+1)'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? (PW+1)'(rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff[PW-1:0]] <= push_data;
      end
   end

endmodule

// File: rtl/core/sparse_squared_distance_engine.sv
// ----------------------------------------------------------------------------
// sparse_squared_distance_engine
// Squared Euclidean distance between a sparse query and sparse candidates.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one nonzero entry per transfer: req_op selects query or
//  candidate, req_feature_index the feature, req_value a signed Q16.16 value,
//  req_last the final entry of the vector. The first query entry after a
//  finished vector starts a new query. rsp_* returns one result per
//  candidate, on its last entry: saturated Q32.32 distance, the candidate's
//  ordinal since the query began, and an overflow flag.
//  Throughput is one entry per cycle while req_stall is low, set by the
//  single store read and the one multiply-add per entry. After the transfer
//  of a candidate's last entry, its result reaches rsp_* after the store
//  read, multiply, accumulate, combine and output buffer write. Up to 8
//  results buffer at the output; with all reserved, req_stall rises until
//  the receiver takes one. Reset (synchronous) clears the control state and
//  then sweeps every feature store entry with req_stall high. Store entries
//  are tagged with a query epoch; a new query that finds the epoch at 255
//  repeats that sweep before its first entry is taken.
// ----------------------------------------------------------------------------
module sparse_squared_distance_engine #(
   parameter int FEATURE_COUNT = 4096,
   parameter int VALUE_BITS    = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [ssde_pkg::IDX_BITS-1:0]        req_feature_index,
   input  logic signed [ssde_pkg::DATA_BITS-1:0] req_value,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ssde_pkg::ACC_BITS-1:0] rsp_distance,
   output logic [ssde_pkg::CNT_BITS-1:0]        rsp_candidate_number,
   output logic                                 rsp_overflow
);

   localparam int CW = ssde_pkg::FIFO_PTR_BITS + 1;

   ssde_pkg::prod_type prod;
   ssde_pkg::rsp_type  push_data, rsp_data;
   logic               push;
   logic [CW-1:0]      credit_ff, credit_in;
   logic               credit_full, reserve, release_slot;

   // One output slot is reserved per candidate-last transfer.
   assign credit_full  = credit_ff == CW'(ssde_pkg::FIFO_DEPTH);
   assign reserve      = req_valid && !req_stall && (req_op == ssde_pkg::OP_CAND) && req_last;
   assign release_slot = rsp_valid && !rsp_stall;

   always_comb begin
      credit_in = credit_ff;
      if (reserve && !release_slot) begin
         credit_in = CW'(credit_ff + 1'b1);
      end else if (!reserve && release_slot) begin
         credit_in = CW'(credit_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   ssde_front #(
      .FEATURE_COUNT (FEATURE_COUNT),
      .VALUE_BITS    (VALUE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_feature_index (req_feature_index),
      .req_value         (req_value),
      .req_last          (req_last),
      .credit_full       (credit_full),
      .prod              (prod)
   );

   ssde_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .prod      (prod),
      .push      (push),
      .push_data (push_data)
   );

   ssde_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_distance         = rsp_data.distance;
   assign rsp_candidate_number = rsp_data.candidate_number;
   assign rsp_overflow         = rsp_data.overflow;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CW'(ssde_pkg::FIFO_DEPTH))
      else $error("output credit count above buffer depth");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      reserve |-> ##4 push)
      else $error("candidate result did not reach the output buffer on time");

   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      push |-> (credit_ff != '0))
      else $error("result written without a reserved slot");

   a_valid_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (credit_ff != '0))
      else $error("buffered result without a reserved slot");

endmodule
